[rtl/tat_pkg.sv]
// Shared constants and types of the tag access table.
package tat_pkg;

   localparam int TABLE_DEPTH   = 256;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int ID_W          = 32;
   localparam int TIME_W        = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_PRESENT = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_KNOWN     = 3'd0,
      STAT_ADDED     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_REMOVED   = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_SHIFT_READ,
      ST_SHIFT_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic              grant;
      logic [TIME_W-1:0] seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   tag_id;
      logic              grant;
      logic [TIME_W-1:0] now_time;
   } item_type;

   typedef struct packed {
      status_type               status;
      logic                     allowed;
      logic [TIME_W-1:0]        seen_time;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } result_type;

endpackage

[rtl/tat_if.sv]
// Request and response channel interfaces of the tag access table.
interface tat_req_if;
   logic                        valid;
   logic                        ready;
   logic [tat_pkg::CMD_W-1:0]   command;
   logic [tat_pkg::ID_W-1:0]    tag_id;
   logic                        grant;
   logic [tat_pkg::TIME_W-1:0]  now_time;

   modport source (output valid, command, tag_id, grant, now_time, input ready);
   modport sink   (input valid, command, tag_id, grant, now_time, output ready);
endinterface

interface tat_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tat_pkg::STATUS_W-1:0]       status;
   logic                               allowed;
   logic [tat_pkg::TIME_W-1:0]         seen_time;
   logic [tat_pkg::ENTRY_COUNT_W-1:0]  entry_count;

   modport source (output valid, status, allowed, seen_time, entry_count, input ready);
   modport sink   (input valid, status, allowed, seen_time, entry_count, output ready);
endinterface

[rtl/tag_access_table.sv]
// Top level of the tag access table: sequencer around the entry RAM.
//
//   channel | dir | beat payload
//   --------+-----+--------------------------------------------
//   req     | in  | command, tag_id, grant, now_time
//   rsp     | out | status, allowed, seen_time, entry_count
//
// Each entry checked costs a RAM read, then a compare, so a search steps
// through the n stored entries in order; a remove then moves each later
// entry down by a read and a write. Rate is set by the single RAM read port.
// Reset clears the count and control only; the RAM needs no clearing pass.
// A finished result waits in an output register; a stalled rsp holds the
// next result in the response state and blocks req until the slot frees.
module tag_access_table (
   input logic       clock,
   input logic       reset,
   tat_req_if.sink   req_bus,
   tat_rsp_if.source rsp_bus
);

   tat_pkg::state_type            state_ff, state_in;
   tat_pkg::item_type             item_ff, item_in;
   tat_pkg::result_type           res_ff, res_in;
   tat_pkg::result_type           rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tat_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [tat_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [tat_pkg::CNT_W-1:0]     idx_next;

   logic                          rd_en;
   logic [tat_pkg::IDX_W-1:0]     rd_addr;
   logic                          wr_en;
   logic [tat_pkg::IDX_W-1:0]     wr_addr;
   tat_pkg::entry_type            wr_data;
   tat_pkg::entry_type            rd_data;

   tat_ram #(
      .WIDTH (tat_pkg::ENTRY_W),
      .DEPTH (tat_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign idx_next = idx_ff + tat_pkg::CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[tat_pkg::IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[tat_pkg::IDX_W-1:0];
      wr_data      = rd_data;
      req_bus.ready = (state_ff == tat_pkg::ST_IDLE);

      case (state_ff)
         tat_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               item_in.command  = req_bus.command;
               item_in.tag_id   = req_bus.tag_id;
               item_in.grant    = req_bus.grant;
               item_in.now_time = req_bus.now_time;
               idx_in           = '0;
               res_in.status    = tat_pkg::STAT_NOT_FOUND;
               res_in.allowed   = 1'b0;
               res_in.seen_time = '0;
               res_in.entry_count = '0;
               if (req_bus.command == tat_pkg::CMD_PRESENT ||
                   req_bus.command == tat_pkg::CMD_REMOVE ||
                   req_bus.command == tat_pkg::CMD_QUERY) begin
                  state_in = tat_pkg::ST_READ;
               end else begin
                  state_in = tat_pkg::ST_RESP;
               end
            end
         end

         tat_pkg::ST_READ: begin
            if (idx_ff == count_ff) begin
               // searched every entry without a match
               state_in = tat_pkg::ST_RESP;
               if (item_ff.command == tat_pkg::CMD_PRESENT) begin
                  if (count_ff < tat_pkg::CNT_W'(tat_pkg::TABLE_DEPTH)) begin
                     wr_en          = 1'b1;
                     wr_data.id     = item_ff.tag_id;
                     wr_data.grant  = item_ff.grant;
                     wr_data.seen   = item_ff.now_time;
                     count_in       = count_ff + tat_pkg::CNT_W'(1);
                     res_in.status  = tat_pkg::STAT_ADDED;
                     res_in.allowed = item_ff.grant;
                  end else begin
                     res_in.status  = tat_pkg::STAT_FULL;
                  end
               end
            end else begin
               rd_en    = 1'b1;
               state_in = tat_pkg::ST_COMPARE;
            end
         end

         tat_pkg::ST_COMPARE: begin
            if (rd_data.id == item_ff.tag_id) begin
               res_in.allowed = rd_data.grant;
               case (item_ff.command)
                  tat_pkg::CMD_PRESENT: begin
                     wr_en            = 1'b1;
                     wr_data.seen     = item_ff.now_time;
                     res_in.status    = tat_pkg::STAT_KNOWN;
                     res_in.seen_time = item_ff.now_time;
                     state_in         = tat_pkg::ST_RESP;
                  end
                  tat_pkg::CMD_REMOVE: begin
                     res_in.status    = tat_pkg::STAT_REMOVED;
                     res_in.seen_time = rd_data.seen;
                     state_in         = tat_pkg::ST_SHIFT_READ;
                  end
                  default: begin
                     res_in.status    = tat_pkg::STAT_KNOWN;
                     res_in.seen_time = rd_data.seen;
                     state_in         = tat_pkg::ST_RESP;
                  end
               endcase
            end else begin
               idx_in   = idx_next;
               state_in = tat_pkg::ST_READ;
            end
         end

         tat_pkg::ST_SHIFT_READ: begin
            if (idx_next >= count_ff) begin
               count_in = count_ff - tat_pkg::CNT_W'(1);
               state_in = tat_pkg::ST_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_next[tat_pkg::IDX_W-1:0];
               state_in = tat_pkg::ST_SHIFT_WRITE;
            end
         end

         tat_pkg::ST_SHIFT_WRITE: begin
            // move the later entry down one place
            wr_en    = 1'b1;
            idx_in   = idx_next;
            state_in = tat_pkg::ST_SHIFT_READ;
         end

         tat_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = res_ff;
               rsp_in.entry_count = tat_pkg::ENTRY_COUNT_W'(count_ff);
               state_in           = tat_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tat_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tat_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      idx_ff  <= idx_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.allowed     = rsp_ff.allowed;
   assign rsp_bus.seen_time   = rsp_ff.seen_time;
   assign rsp_bus.entry_count = rsp_ff.entry_count;

endmodule

[rtl/tat_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module tat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tag_access_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for tag_access_table: directed rows, then random table traffic.
module tag_access_table_tb;
   import tat_pkg::*;

   localparam int IDLE_PCT      = 31;
   localparam int SMALL_LIMIT   = 20;
   localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 16;
   localparam int RUN_LIMIT     = 4_000_000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum {MIX_SMALL, MIX_FILL, MIX_FULL, MIX_DRAIN} mix_type;

   typedef struct packed {
      item_type   beat;
      logic       typed;
      result_type want;
   } stim_row;

   logic        clock;
   logic        reset;
   bit          quiet = 1'b0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Shadow copy of the tag table
   logic [ID_W-1:0]   table_ids    [TABLE_DEPTH];
   logic              table_grants [TABLE_DEPTH];
   logic [TIME_W-1:0] table_times  [TABLE_DEPTH];
   int                table_count = 0;

   result_type pending_results [$];
   stim_row    directed_rows [22];

   tat_req_if req_bus ();
   tat_rsp_if rsp_bus ();

   tag_access_table DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic stim_row row(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                   input logic g, input logic [TIME_W-1:0] now);
      stim_row r;
      r = '0;
      r.beat = '{command: cmd, tag_id: id, grant: g, now_time: now};
      return r;
   endfunction

   function automatic stim_row row_typed(input logic [CMD_W-1:0] cmd,
                                         input logic [ID_W-1:0] id, input logic g,
                                         input logic [TIME_W-1:0] now, input status_type st,
                                         input int al, input logic [TIME_W-1:0] seen,
                                         input int cnt);
      stim_row r;
      r = row(cmd, id, g, now);
      r.typed = 1'b1;
      r.want  = '{status: st, allowed: 1'(al), seen_time: seen,
                  entry_count: ENTRY_COUNT_W'(cnt)};
      return r;
   endfunction

   // Applies one command to the shadow table and returns the response it should give.
   function automatic result_type apply_tag_command(input item_type it);
      result_type r;
      int pos;
      int i;
      r        = '0;
      r.status = STAT_NOT_FOUND;
      pos      = -1;
      for (i = table_count - 1; i >= 0; i--)
         if (table_ids[i] == it.tag_id) pos = i;   // lowest match wins
      case (it.command)
         CMD_PRESENT: begin
            if (pos >= 0) begin
               table_times[pos] = it.now_time;
               r.status    = STAT_KNOWN;
               r.allowed   = table_grants[pos];
               r.seen_time = it.now_time;
            end else if (table_count < TABLE_DEPTH) begin
               table_ids[table_count]    = it.tag_id;
               table_grants[table_count] = it.grant;
               table_times[table_count]  = it.now_time;
               table_count++;
               r.status  = STAT_ADDED;
               r.allowed = it.grant;
            end else begin
               r.status = STAT_FULL;
            end
         end
         CMD_REMOVE: begin
            if (pos >= 0) begin
               r.status    = STAT_REMOVED;
               r.allowed   = table_grants[pos];
               r.seen_time = table_times[pos];
               for (i = pos; i < table_count - 1; i++) begin
                  table_ids[i]    = table_ids[i + 1];
                  table_grants[i] = table_grants[i + 1];
                  table_times[i]  = table_times[i + 1];
               end
               table_count--;
            end
         end
         CMD_QUERY: begin
            if (pos >= 0) begin
               r.status    = STAT_KNOWN;
               r.allowed   = table_grants[pos];
               r.seen_time = table_times[pos];
            end
         end
         default: ;
      endcase
      r.entry_count = ENTRY_COUNT_W'(table_count);
      return r;
   endfunction

   function automatic logic [ID_W-1:0] known_tag();
      if (table_count == 0) return $urandom();
      return table_ids[$urandom_range(table_count - 1)];
   endfunction

   function automatic item_type next_random_beat(input mix_type mix);
      item_type it;
      int pick;
      bit hit;
      it.command  = CMD_PRESENT;
      it.tag_id   = $urandom();
      it.grant    = 1'($urandom_range(1));
      it.now_time = $urandom();
      pick        = $urandom_range(99);
      hit         = 1'b1;
      case (mix)
         MIX_SMALL: begin
            if (pick < 30) begin
               // new tag, unless the table has reached the small working set
               it.command = (table_count < SMALL_LIMIT) ? CMD_PRESENT : CMD_REMOVE;
               hit        = (table_count >= SMALL_LIMIT);
            end else if (pick < 50) begin
               it.command = CMD_PRESENT;
            end else if (pick < 65) begin
               it.command = CMD_QUERY;
            end else if (pick < 70) begin
               it.command = CMD_QUERY;
               hit        = 1'b0;
            end else if (pick < 90) begin
               it.command = CMD_REMOVE;
            end else if (pick < 95) begin
               it.command = CMD_REMOVE;
               hit        = 1'b0;
            end else begin
               it.command = CMD_UNUSED;
               hit        = 1'b0;
            end
         end
         MIX_FILL: begin
            if (pick < 85) hit = 1'b0;
            else if (pick >= 92) it.command = CMD_QUERY;
         end
         MIX_FULL: begin
            if (pick < 30) begin
               hit = 1'b0;
            end else if (pick < 50) begin
               it.command = CMD_PRESENT;
            end else if (pick < 65) begin
               it.command = CMD_QUERY;
            end else if (pick < 80) begin
               it.command = CMD_REMOVE;
            end else if (pick < 90) begin
               it.command = CMD_QUERY;
               hit        = 1'b0;
            end else begin
               it.command = CMD_UNUSED;
               hit        = 1'b0;
            end
         end
         default: begin
            if (pick < 85) it.command = CMD_REMOVE;
            else if (pick >= 93) it.command = CMD_QUERY;
         end
      endcase
      if (hit) it.tag_id = known_tag();
      return it;
   endfunction

   task automatic send_tag_beat(input item_type it, input logic typed, input result_type want);
      result_type predicted;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (!quiet && $urandom_range(99) < IDLE_PCT);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= it.command;
      req_bus.tag_id   <= it.tag_id;
      req_bus.grant    <= it.grant;
      req_bus.now_time <= it.now_time;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = apply_tag_command(it);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Response side: random back-pressure and in-order checking
   initial begin
      result_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response beat with nothing pending");
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_bus.status, want.status));
               if (rsp_bus.allowed !== want.allowed)
                  report_mismatch($sformatf("allowed got %0b want %0b",
                                            rsp_bus.allowed, want.allowed));
               if (rsp_bus.seen_time !== want.seen_time)
                  report_mismatch($sformatf("seen_time got %h want %h",
                                            rsp_bus.seen_time, want.seen_time));
               if (rsp_bus.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_bus.entry_count, want.entry_count));
            end
         end
         rsp_bus.ready <= !reset && (quiet || $urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tag_access_table test failed");
      $finish;
   end

   initial begin
      int n;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.command  <= CMD_PRESENT;
      req_bus.tag_id   <= '0;
      req_bus.grant    <= 1'b0;
      req_bus.now_time <= '0;

      directed_rows = '{
         row_typed(CMD_QUERY,   32'h0,        1'b0, 32'h0,        STAT_NOT_FOUND, 0, 0, 0),
         row_typed(CMD_REMOVE,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, STAT_NOT_FOUND, 0, 0, 0),
         row_typed(CMD_PRESENT, 32'h0,        1'b1, 32'hFFFFFFFF, STAT_ADDED,     1, 0, 1),
         row_typed(CMD_PRESENT, 32'hFFFFFFFF, 1'b0, 32'h0,        STAT_ADDED,     0, 0, 2),
         row(CMD_PRESENT, 32'h0,        1'b0, 32'h12345678),   // stored grant, not this one
         row(CMD_QUERY,   32'hFFFFFFFF, 1'b1, 32'h0),
         row_typed(CMD_UNUSED,  32'h0,        1'b1, 32'h0,        STAT_NOT_FOUND, 0, 0, 2),
         row(CMD_PRESENT, 32'hA5A5A5A5, 1'b1, 32'h5A5A5A5A),
         row(CMD_REMOVE,  32'h0,        1'b0, 32'h0),          // first entry, rest shift down
         row_typed(CMD_QUERY,   32'h0,        1'b0, 32'h0,        STAT_NOT_FOUND, 0, 0, 2),
         row(CMD_QUERY,   32'hA5A5A5A5, 1'b0, 32'hFFFFFFFF),
         row(CMD_REMOVE,  32'hA5A5A5A5, 1'b0, 32'h0),          // last entry, nothing to move
         row_typed(CMD_REMOVE,  32'h12345678, 1'b0, 32'h0,        STAT_NOT_FOUND, 0, 0, 1),
         row(CMD_PRESENT, 32'hFFFFFFFF, 1'b1, 32'h7),
         row(CMD_REMOVE,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF),
         row_typed(CMD_UNUSED,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, STAT_NOT_FOUND, 0, 0, 0),
         row_typed(CMD_QUERY,   32'h0,        1'b1, 32'h0,        STAT_NOT_FOUND, 0, 0, 0),
         row(CMD_PRESENT, 32'h80000001, 1'b0, 32'h80000000),
         row(CMD_PRESENT, 32'h00000001, 1'b1, 32'h00000001),
         row(CMD_QUERY,   32'h80000001, 1'b0, 32'h0),
         row(CMD_PRESENT, 32'h80000001, 1'b1, 32'hDEADBEEF),
         row(CMD_REMOVE,  32'h00000001, 1'b0, 32'h0)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_tag_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

      // small working set keeps searches short
      for (n = 0; n < 520; n++) begin
         quiet = (n >= 300 && n < 420);
         if (n == 200) wait_for_results();
         send_tag_beat(next_random_beat(MIX_SMALL), 1'b0, '0);
      end
      quiet = 1'b0;

      while (table_count < TABLE_DEPTH)
         send_tag_beat(next_random_beat(MIX_FILL), 1'b0, '0);
      repeat (40) send_tag_beat(next_random_beat(MIX_FULL), 1'b0, '0);
      while (table_count > 8)
         send_tag_beat(next_random_beat(MIX_DRAIN), 1'b0, '0);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tag_access_table test passed");
      else
         $display("tag_access_table test failed");
      $finish;
   end

endmodule

[files.f]
rtl/tat_pkg.sv
rtl/tat_if.sv
rtl/tat_ram.sv
rtl/tag_access_table.sv
bench/tag_access_table_tb.sv
